### design/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types, codes and constants of the priority run queue.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int unsigned TableEntries = 16;
   localparam int unsigned IdxWidth     = $clog2(TableEntries);
   localparam int unsigned CntWidth     = $clog2(TableEntries + 1);

   localparam logic [2:0] MODE_INSERT  = 3'd0;
   localparam logic [2:0] MODE_MULTI   = 3'd1;
   localparam logic [2:0] MODE_REPEAT  = 3'd2;
   localparam logic [2:0] MODE_EXTRACT = 3'd3;
   localparam logic [2:0] MODE_CLEAR   = 3'd4;

   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_MERGED   = 3'd2;
   localparam logic [2:0] ST_REJECTED = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_NONE     = 3'd5;

   localparam logic [1:0] CSR_QUANTUM = 2'd0;
   localparam logic [1:0] CSR_MIN_PRI = 2'd1;
   localparam logic [1:0] CSR_MAX_PRI = 2'd2;

   localparam int unsigned MaxResults = 16;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_CHECK, S_INS_SCAN, S_INS_SHIFT, S_RUN, S_REM_SHIFT,
      S_EXT_SCAN, S_RESULT, S_WAIT
   } state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  prio;
      logic [15:0] proc_id;
      logic [31:0] time_amount;
      logic [7:0]  run_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  unused_procs;
      logic [2:0]  out_prio;
      logic [15:0] out_id;
      logic [31:0] out_time;
      logic        last;
   } rsp_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;       // latch request, start remainder
      logic div_step;   // one remainder bit
      logic scan_step;  // advance scan pointer
      logic shift_up;   // shift one entry upward (insert)
      logic write_new;  // write new entry at pointer
      logic merge;      // saturating add at pointer
      logic run_sub;    // subtract slice at pointer
      logic rem_start;  // start removal at pointer
      logic rem_step;   // move one entry down
      logic rem_end;    // finish removal
      logic run_next;   // advance pointer after run
      logic count_dec;  // decrement run count
      logic clear;
      logic ext_emit;   // latch extracted entry as result
      logic [2:0] res_status;
      logic res_last;
      logic res_set;    // build a plain result
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic slice_ok;
      logic prio_ok;
      logic [2:0] mode;
      logic ptr_end;      // pointer reached entry count
      logic id_hit;
      logic prio_lower;   // new prio above entry prio
      logic full;
      logic shift_done;
      logic rem_done;
      logic cnt_zero;
      logic time_gt;      // entry time above slice
      logic prio_match;
      logic emit_full;
      logic any_emitted;
   } sts_type;

endpackage

### design/prq_if.sv
// ----------------------------------------------------------------------------
// prq_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface prq_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/prq_csr_if.sv
// ----------------------------------------------------------------------------
// prq_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface prq_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

### design/prq_datapath.sv
// ----------------------------------------------------------------------------
// prq_datapath
// Entry table, configuration registers, remainder unit and result register.
// ----------------------------------------------------------------------------
module prq_datapath (
   input  logic              clock,
   input  logic              reset,
   input  prq_pkg::req_type  req,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   input  prq_pkg::cmd_type  cmd,
   output prq_pkg::sts_type  sts,
   output prq_pkg::rsp_type  rsp
);
   localparam int unsigned IW = prq_pkg::IdxWidth;
   localparam int unsigned CW = prq_pkg::CntWidth;

   logic [15:0] quantum_ff;
   logic [2:0]  min_pri_ff, max_pri_ff;
   prq_pkg::req_type req_ff;
   logic [7:0]  cnt_ff;
   logic [CW-1:0] count_ff, ptr_ff, shf_ff;
   logic [2:0]  ent_prio_ff [prq_pkg::TableEntries];
   logic [15:0] ent_id_ff   [prq_pkg::TableEntries];
   logic [31:0] ent_time_ff [prq_pkg::TableEntries];
   logic [16:0] rem_ff;
   logic [5:0]  div_bit_ff;
   logic [4:0]  emitted_ff;
   prq_pkg::rsp_type rsp_ff;

   logic [IW-1:0] pidx, sidx;
   logic [16:0] rem_sh, rem_in;
   logic [15:0] q_eff;
   logic [32:0] sum;

   assign pidx  = ptr_ff[IW-1:0];
   assign sidx  = shf_ff[IW-1:0];
   assign q_eff = (quantum_ff == 16'd0) ? 16'd1 : quantum_ff;
   assign rem_sh = {rem_ff[15:0], req_ff.time_amount[5'(div_bit_ff - 6'd1)]};
   assign rem_in = (rem_sh >= {1'b0, q_eff}) ? rem_sh - {1'b0, q_eff} : rem_sh;
   assign sum    = {1'b0, ent_time_ff[pidx]} + {1'b0, req_ff.time_amount};

   always_comb begin
      sts.div_done    = (div_bit_ff == 6'd0);
      sts.slice_ok    = (req_ff.time_amount != 32'd0) && (rem_ff == 17'd0);
      sts.prio_ok     = (req_ff.prio >= min_pri_ff) && (req_ff.prio <= max_pri_ff);
      sts.mode        = req_ff.mode;
      sts.ptr_end     = (ptr_ff >= count_ff);
      sts.id_hit      = (ent_id_ff[pidx] == req_ff.proc_id);
      sts.prio_lower  = (req_ff.prio > ent_prio_ff[pidx]);
      sts.full        = (count_ff == CW'(prq_pkg::TableEntries));
      sts.shift_done  = (shf_ff <= ptr_ff);
      sts.rem_done    = (CW'(shf_ff + 1'b1) >= count_ff);
      sts.cnt_zero    = (cnt_ff == 8'd0);
      sts.time_gt     = (ent_time_ff[pidx] > req_ff.time_amount);
      sts.prio_match  = (ent_prio_ff[pidx] == req_ff.prio);
      sts.emit_full   = (emitted_ff == 5'(prq_pkg::MaxResults));
      sts.any_emitted = (emitted_ff != 5'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= 16'd10;
         min_pri_ff <= 3'd1;
         max_pri_ff <= 3'd5;
         count_ff   <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               prq_pkg::CSR_QUANTUM: quantum_ff <= csr_wdata;
               prq_pkg::CSR_MIN_PRI: min_pri_ff <= csr_wdata[2:0];
               prq_pkg::CSR_MAX_PRI: max_pri_ff <= csr_wdata[2:0];
               default: ;
            endcase
         end
         if (cmd.clear) count_ff <= '0;
         else if (cmd.write_new) count_ff <= CW'(count_ff + 1'b1);
         else if (cmd.rem_end) count_ff <= CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff     <= req;
         cnt_ff     <= req.run_count;
         rem_ff     <= '0;
         div_bit_ff <= 6'd32;
         ptr_ff     <= '0;
         emitted_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff     <= rem_in;
         div_bit_ff <= div_bit_ff - 6'd1;
      end
      if (cmd.scan_step || cmd.run_next) ptr_ff <= CW'(ptr_ff + 1'b1);
      if (cmd.count_dec) cnt_ff <= cnt_ff - 8'd1;
      if (cmd.load || cmd.rem_start) shf_ff <= cmd.load ? count_ff : ptr_ff;
      else if (cmd.shift_up) begin
         ent_prio_ff[sidx] <= ent_prio_ff[IW'(shf_ff - 1'b1)];
         ent_id_ff[sidx]   <= ent_id_ff[IW'(shf_ff - 1'b1)];
         ent_time_ff[sidx] <= ent_time_ff[IW'(shf_ff - 1'b1)];
         shf_ff <= CW'(shf_ff - 1'b1);
      end else if (cmd.rem_step) begin
         ent_prio_ff[sidx] <= ent_prio_ff[IW'(shf_ff + 1'b1)];
         ent_id_ff[sidx]   <= ent_id_ff[IW'(shf_ff + 1'b1)];
         ent_time_ff[sidx] <= ent_time_ff[IW'(shf_ff + 1'b1)];
         shf_ff <= CW'(shf_ff + 1'b1);
      end
      if (cmd.write_new) begin
         ent_prio_ff[pidx] <= req_ff.prio;
         ent_id_ff[pidx]   <= req_ff.proc_id;
         ent_time_ff[pidx] <= req_ff.time_amount;
      end
      if (cmd.merge) ent_time_ff[pidx] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (cmd.run_sub) ent_time_ff[pidx] <= ent_time_ff[pidx] - req_ff.time_amount;
      if (cmd.ext_emit) begin
         rsp_ff.status       <= prq_pkg::ST_DONE;
         rsp_ff.unused_procs <= 8'd0;
         rsp_ff.out_prio     <= ent_prio_ff[pidx];
         rsp_ff.out_id       <= ent_id_ff[pidx];
         rsp_ff.out_time     <= ent_time_ff[pidx];
         rsp_ff.last         <= 1'b0;
         emitted_ff          <= emitted_ff + 5'd1;
      end
      if (cmd.res_set) begin
         rsp_ff.status       <= cmd.res_status;
         rsp_ff.unused_procs <= (req_ff.mode == prq_pkg::MODE_MULTI) ? cnt_ff : 8'd0;
         rsp_ff.out_prio     <= '0;
         rsp_ff.out_id       <= '0;
         rsp_ff.out_time     <= '0;
         rsp_ff.last         <= 1'b1;
      end
      if (cmd.res_last) rsp_ff.last <= 1'b1;
   end

   assign rsp = rsp_ff;
endmodule

### design/prq_ctrl.sv
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer: walks the table for each operation and hands results out.
// ----------------------------------------------------------------------------
module prq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  prq_pkg::sts_type sts,
   output prq_pkg::cmd_type cmd
);
   prq_pkg::state_type state_ff, state_in;
   prq_pkg::state_type after_ff, after_in;   // where removal returns
   logic pend_ff, pend_in;                   // an extracted entry waits to be emitted
   logic keep_ff, keep_in;                   // extraction continues after this result

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prq_pkg::S_IDLE;
         after_ff <= prq_pkg::S_IDLE;
         pend_ff  <= 1'b0;
         keep_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         pend_ff  <= pend_in;
         keep_ff  <= keep_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      after_in  = after_ff;
      pend_in   = pend_ff;
      keep_in   = keep_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         prq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = prq_pkg::S_DIV;
            end
         end
         prq_pkg::S_DIV: begin
            if (sts.div_done) state_in = prq_pkg::S_CHECK;
            else cmd.div_step = 1'b1;
         end
         prq_pkg::S_CHECK: begin
            cmd.res_set = 1'b1;
            cmd.res_status = prq_pkg::ST_DONE;
            state_in = prq_pkg::S_RESULT;
            case (sts.mode)
               prq_pkg::MODE_INSERT: begin
                  if (!sts.slice_ok || !sts.prio_ok) cmd.res_status = prq_pkg::ST_REJECTED;
                  else begin
                     cmd.res_set = 1'b0;
                     state_in = prq_pkg::S_INS_SCAN;
                  end
               end
               prq_pkg::MODE_MULTI, prq_pkg::MODE_REPEAT: begin
                  if (!sts.slice_ok) cmd.res_status = prq_pkg::ST_REJECTED;
                  else begin
                     cmd.res_set = 1'b0;
                     state_in = prq_pkg::S_RUN;
                  end
               end
               prq_pkg::MODE_EXTRACT: begin
                  cmd.res_set = 1'b0;
                  pend_in = 1'b0;
                  state_in = prq_pkg::S_EXT_SCAN;
               end
               prq_pkg::MODE_CLEAR: cmd.clear = 1'b1;
               default: cmd.res_status = prq_pkg::ST_REJECTED;
            endcase
         end
         prq_pkg::S_INS_SCAN: begin
            if (!sts.ptr_end && sts.id_hit) begin
               cmd.merge = 1'b1;
               cmd.res_set = 1'b1;
               cmd.res_status = prq_pkg::ST_MERGED;
               state_in = prq_pkg::S_RESULT;
            end else if (sts.ptr_end || sts.prio_lower) begin
               if (sts.full) begin
                  cmd.res_set = 1'b1;
                  cmd.res_status = prq_pkg::ST_FULL;
                  state_in = prq_pkg::S_RESULT;
               end else state_in = prq_pkg::S_INS_SHIFT;
            end else cmd.scan_step = 1'b1;
         end
         prq_pkg::S_INS_SHIFT: begin
            if (sts.shift_done) begin
               cmd.write_new = 1'b1;
               cmd.res_set = 1'b1;
               cmd.res_status = prq_pkg::ST_INSERTED;
               state_in = prq_pkg::S_RESULT;
            end else cmd.shift_up = 1'b1;
         end
         prq_pkg::S_RUN: begin
            if (sts.cnt_zero || sts.ptr_end) begin
               cmd.res_set = 1'b1;
               cmd.res_status = prq_pkg::ST_DONE;
               state_in = prq_pkg::S_RESULT;
            end else begin
               cmd.count_dec = 1'b1;
               if (sts.time_gt) begin
                  cmd.run_sub = 1'b1;
                  if (sts.mode == prq_pkg::MODE_MULTI) cmd.run_next = 1'b1;
               end else begin
                  cmd.rem_start = 1'b1;
                  after_in = prq_pkg::S_RUN;
                  state_in = prq_pkg::S_REM_SHIFT;
               end
            end
         end
         prq_pkg::S_REM_SHIFT: begin
            if (sts.rem_done) begin
               cmd.rem_end = 1'b1;
               state_in = after_ff;
            end else cmd.rem_step = 1'b1;
         end
         prq_pkg::S_EXT_SCAN: begin
            if (pend_ff) begin
               // A held entry goes out once we know whether another follows.
               if (sts.ptr_end || sts.emit_full) begin
                  pend_in = 1'b0;
                  keep_in = 1'b0;
                  cmd.res_last = 1'b1;
                  state_in = prq_pkg::S_RESULT;
               end else if (sts.prio_match) begin
                  keep_in = 1'b1;
                  state_in = prq_pkg::S_RESULT;
               end else cmd.scan_step = 1'b1;
            end else if (sts.ptr_end || sts.emit_full) begin
               if (!sts.any_emitted) begin
                  cmd.res_set = 1'b1;
                  cmd.res_status = prq_pkg::ST_NONE;
               end
               keep_in = 1'b0;
               state_in = prq_pkg::S_RESULT;
            end else if (sts.prio_match) begin
               cmd.ext_emit = 1'b1;
               cmd.rem_start = 1'b1;
               pend_in = 1'b1;
               after_in = prq_pkg::S_EXT_SCAN;
               state_in = prq_pkg::S_REM_SHIFT;
            end else cmd.scan_step = 1'b1;
         end
         prq_pkg::S_RESULT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (keep_ff) begin
                  keep_in = 1'b0;
                  pend_in = 1'b0;
                  state_in = prq_pkg::S_EXT_SCAN;
               end else state_in = prq_pkg::S_IDLE;
            end
         end
         default: state_in = prq_pkg::S_IDLE;
      endcase
   end
endmodule

### design/priority_run_queue.sv
// ----------------------------------------------------------------------------
// priority_run_queue
// Run queue of up to sixteen processes kept in priority order.
// ----------------------------------------------------------------------------
// Use: a request transaction on req carries a mode (insert, multi-run,
// repeat-run, extract, clear) and its operands. Each request yields one or
// more response transactions on rsp; the final one of a request has last set.
// Extraction yields one response per removed entry, up to sixteen.
// Configuration (quantum, lowest and highest priority) is written on csr,
// which is always ready, and should only be written while the queue is idle.
// Operation: a request first goes through a bit-serial remainder check of
// the time against the quantum, then, for modes that need it, walks the
// table one entry a cycle; each removal or insertion shifts the tail one entry a cycle.
// One request is handled at a time; req is ready only while idle.
// Reset empties the table and restores the configuration defaults.
// If the receiver stalls rsp, the result is held and work waits for it.
// ----------------------------------------------------------------------------
module priority_run_queue (
   input logic clock,
   input logic reset,
   prq_if.sink     req,
   prq_if.source   rsp,
   prq_csr_if.sink csr
);
   prq_pkg::cmd_type cmd;
   prq_pkg::sts_type sts;
   prq_pkg::rsp_type rsp_data;

   assign csr.ready = 1'b1;
   assign rsp.data  = rsp_data;

   prq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   prq_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req.data),
      .csr_we    (csr.valid),
      .csr_index (csr.index),
      .csr_wdata (csr.wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp       (rsp_data)
   );
endmodule

### design/prq_checker.sv
// ----------------------------------------------------------------------------
// prq_checker
// Port-level checks of the run queue, bound to the top level.
// ----------------------------------------------------------------------------
module prq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_status,
   input logic rsp_last
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while a response waits");
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("second request taken");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= prq_pkg::ST_NONE) else $error("bad status");
   // Only extracted entries share a request; every other response is its last.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != prq_pkg::ST_DONE) |-> rsp_last)
      else $error("single response without last");
endmodule

bind priority_run_queue prq_checker u_prq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_status (rsp.data.status),
   .rsp_last   (rsp.data.last)
);

### tb/priority_run_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_run_queue_checker
// Watches the request, response and register channels of the run queue. It
// keeps its own copy of the process table and the registers, works out the
// responses that each accepted request must give, and compares every
// accepted response, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module priority_run_queue_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  prq_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  prq_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   output int                outstanding,
   output int                fail_count
);

   logic [15:0] quantum;
   logic [2:0]  lowest_prio;
   logic [2:0]  highest_prio;

   int          proc_count;
   logic [2:0]  proc_prio [prq_pkg::TableEntries];
   logic [15:0] proc_id   [prq_pkg::TableEntries];
   logic [31:0] proc_time [prq_pkg::TableEntries];

   prq_pkg::rsp_type due_responses[$];

   initial fail_count = 0;
   assign outstanding = due_responses.size();

   task automatic report_mismatch(string what, longint want, longint got);
      $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
      fail_count++;
   endtask

   function automatic bit slice_fits(logic [31:0] t);
      logic [31:0] q;
      q = (quantum == 0) ? 32'd1 : {16'd0, quantum};
      return t != 0 && (t % q) == 0;
   endfunction

   function automatic prq_pkg::rsp_type plain(logic [2:0] st, logic [7:0] unused);
      prq_pkg::rsp_type r;
      r = '0;
      r.status       = st;
      r.unused_procs = unused;
      r.last         = 1'b1;
      return r;
   endfunction

   task automatic drop_entry(int at);
      for (int j = at; j + 1 < proc_count; j++) begin
         proc_prio[j] = proc_prio[j + 1];
         proc_id[j]   = proc_id[j + 1];
         proc_time[j] = proc_time[j + 1];
      end
      proc_count--;
   endtask

   task automatic insert_process(prq_pkg::req_type r);
      int          pos;
      logic [32:0] sum;
      if (!slice_fits(r.time_amount) || r.prio < lowest_prio || r.prio > highest_prio) begin
         due_responses.push_back(plain(prq_pkg::ST_REJECTED, 8'd0));
         return;
      end
      pos = 0;
      while (pos < proc_count && proc_id[pos] != r.proc_id && r.prio <= proc_prio[pos])
         pos++;
      if (pos < proc_count && proc_id[pos] == r.proc_id) begin
         sum = {1'b0, proc_time[pos]} + {1'b0, r.time_amount};
         proc_time[pos] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         due_responses.push_back(plain(prq_pkg::ST_MERGED, 8'd0));
      end else if (proc_count >= prq_pkg::TableEntries) begin
         due_responses.push_back(plain(prq_pkg::ST_FULL, 8'd0));
      end else begin
         for (int j = proc_count; j > pos; j--) begin
            proc_prio[j] = proc_prio[j - 1];
            proc_id[j]   = proc_id[j - 1];
            proc_time[j] = proc_time[j - 1];
         end
         proc_prio[pos] = r.prio;
         proc_id[pos]   = r.proc_id;
         proc_time[pos] = r.time_amount;
         proc_count++;
         due_responses.push_back(plain(prq_pkg::ST_INSERTED, 8'd0));
      end
   endtask

   task automatic apply_request(prq_pkg::req_type r);
      int               i;
      int               emitted;
      logic [7:0]       left;
      prq_pkg::rsp_type e;
      left = r.run_count;
      case (r.mode)
         prq_pkg::MODE_INSERT: begin
            insert_process(r);
         end
         prq_pkg::MODE_MULTI: begin
            if (!slice_fits(r.time_amount)) begin
               due_responses.push_back(plain(prq_pkg::ST_REJECTED, left));
            end else begin
               i = 0;
               while (left != 0 && i < proc_count) begin
                  if (proc_time[i] > r.time_amount) begin
                     proc_time[i] -= r.time_amount;
                     i++;
                  end else begin
                     drop_entry(i);
                  end
                  left--;
               end
               due_responses.push_back(plain(prq_pkg::ST_DONE, left));
            end
         end
         prq_pkg::MODE_REPEAT: begin
            if (!slice_fits(r.time_amount)) begin
               due_responses.push_back(plain(prq_pkg::ST_REJECTED, 8'd0));
            end else begin
               while (left != 0 && proc_count != 0) begin
                  if (proc_time[0] > r.time_amount) proc_time[0] -= r.time_amount;
                  else drop_entry(0);
                  left--;
               end
               due_responses.push_back(plain(prq_pkg::ST_DONE, 8'd0));
            end
         end
         prq_pkg::MODE_EXTRACT: begin
            i = 0;
            emitted = 0;
            while (i < proc_count && emitted < prq_pkg::MaxResults) begin
               if (proc_prio[i] == r.prio) begin
                  e = '0;
                  e.status   = prq_pkg::ST_DONE;
                  e.out_prio = proc_prio[i];
                  e.out_id   = proc_id[i];
                  e.out_time = proc_time[i];
                  due_responses.push_back(e);
                  emitted++;
                  drop_entry(i);
               end else begin
                  i++;
               end
            end
            if (emitted == 0) due_responses.push_back(plain(prq_pkg::ST_NONE, 8'd0));
            else due_responses[$].last = 1'b1;
         end
         prq_pkg::MODE_CLEAR: begin
            proc_count = 0;
            due_responses.push_back(plain(prq_pkg::ST_DONE, 8'd0));
         end
         default: begin
            due_responses.push_back(plain(prq_pkg::ST_REJECTED, 8'd0));
         end
      endcase
   endtask

   task automatic check_response(prq_pkg::rsp_type got);
      prq_pkg::rsp_type want;
      if (due_responses.size() == 0) begin
         report_mismatch("unexpected response", 64'd0, 64'(got.status));
         return;
      end
      want = due_responses.pop_front();
      if (got.status !== want.status)
         report_mismatch("status", 64'(want.status), 64'(got.status));
      if (got.unused_procs !== want.unused_procs)
         report_mismatch("unused_procs", 64'(want.unused_procs), 64'(got.unused_procs));
      if (got.out_prio !== want.out_prio)
         report_mismatch("out_prio", 64'(want.out_prio), 64'(got.out_prio));
      if (got.out_id !== want.out_id)
         report_mismatch("out_id", 64'(want.out_id), 64'(got.out_id));
      if (got.out_time !== want.out_time)
         report_mismatch("out_time", 64'(want.out_time), 64'(got.out_time));
      if (got.last !== want.last)
         report_mismatch("last", 64'(want.last), 64'(got.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         quantum      = 16'd10;
         lowest_prio  = 3'd1;
         highest_prio = 3'd5;
         proc_count   = 0;
         due_responses.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               prq_pkg::CSR_QUANTUM: quantum      = csr_wdata;
               prq_pkg::CSR_MIN_PRI: lowest_prio  = csr_wdata[2:0];
               prq_pkg::CSR_MAX_PRI: highest_prio = csr_wdata[2:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) apply_request(req_data);
         if (rsp_valid && rsp_ready) check_response(rsp_data);
      end
   end

endmodule

### tb/priority_run_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_run_queue_tb
// Drives the run queue with a directed opening and then random requests over
// several register settings and idling patterns. Checking is left to the
// checker module; this top makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module priority_run_queue_tb;

   logic clock;
   logic reset;

   prq_if #(.payload_type(prq_pkg::req_type)) req_ch ();
   prq_if #(.payload_type(prq_pkg::rsp_type)) rsp_ch ();
   prq_csr_if                                 csr_ch ();

   int outstanding;
   int fail_count;

   // Idling percentages for the sender and the receiver, and a count of
   // cycles for which the receiver is to hold off completely.
   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;

   // The registers as the stimulus believes them to be, so that random
   // requests can be aimed at the accepted ranges.
   logic [15:0] cur_quantum;
   logic [2:0]  cur_min;
   logic [2:0]  cur_max;

   priority_run_queue u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   priority_run_queue_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_data    (req_ch.data),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_data    (rsp_ch.data),
      .csr_valid   (csr_ch.valid),
      .csr_ready   (csr_ch.ready),
      .csr_index   (csr_ch.index),
      .csr_wdata   (csr_ch.wdata),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard limit on the run: far beyond the slowest legal run of 187 requests, with stalls.
   initial begin
      #30ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // Receiver: a long hold-off, when asked for, takes precedence over the
   // random stalls. The hold is counted down here, one cycle at a time.
   initial rsp_ch.ready = 1'b0;
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles  <= hold_cycles - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // All tasks below start and finish just after a falling edge.
   task automatic send_request(prq_pkg::req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.wdata <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic configure(logic [15:0] q, logic [2:0] lo, logic [2:0] hi);
      wait_drained();
      write_reg(prq_pkg::CSR_QUANTUM, q);
      write_reg(prq_pkg::CSR_MIN_PRI, {13'd0, lo});
      write_reg(prq_pkg::CSR_MAX_PRI, {13'd0, hi});
      cur_quantum = q;
      cur_min     = lo;
      cur_max     = hi;
   endtask

   function automatic prq_pkg::req_type make_req(logic [2:0] m, logic [2:0] p,
                                                 logic [15:0] id, logic [31:0] t,
                                                 logic [7:0] n);
      prq_pkg::req_type r;
      r.mode        = m;
      r.prio        = p;
      r.proc_id     = id;
      r.time_amount = t;
      r.run_count   = n;
      return r;
   endfunction

   // Times are mostly small exact multiples of the quantum; now and then
   // zero, a raw random word, or the largest multiple that fits.
   function automatic logic [31:0] pick_time(bit for_run);
      longint unsigned q;
      longint unsigned k;
      q = (cur_quantum == 0) ? 1 : cur_quantum;
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return $urandom;
         2: return 32'((64'hFFFF_FFFF / q) * q);
         default: begin
            k = for_run ? $urandom_range(1, 3) : $urandom_range(1, 12);
            return 32'(q * k);
         end
      endcase
   endfunction

   function automatic prq_pkg::req_type random_req();
      prq_pkg::req_type r;
      int               pick;
      logic [2:0]       p;
      logic [15:0]      id;
      logic [7:0]       n;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 4) != 0 && cur_min <= cur_max)
         p = 3'($urandom_range(cur_min, cur_max));
      else
         p = 3'($urandom);
      // A small pool of ids makes merges likely and lets the table fill up.
      id = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(1, 24));
      n  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
      if (pick < 55)
         r = make_req(prq_pkg::MODE_INSERT, p, id, pick_time(1'b0), 8'($urandom));
      else if (pick < 70)
         r = make_req(prq_pkg::MODE_MULTI, p, id, pick_time(1'b1), n);
      else if (pick < 82)
         r = make_req(prq_pkg::MODE_REPEAT, p, id, pick_time(1'b1), n);
      else if (pick < 94)
         r = make_req(prq_pkg::MODE_EXTRACT, 3'($urandom), id, $urandom, n);
      else if (pick < 97)
         r = make_req(prq_pkg::MODE_CLEAR, p, id, $urandom, n);
      else
         r = make_req(3'($urandom_range(5, 7)), p, id, $urandom, n);
      return r;
   endfunction

   task automatic run_random(int count);
      repeat (count) send_request(random_req());
   endtask

   initial begin
      reset         = 1'b1;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles   = 0;
      req_ch.valid  = 1'b0;
      req_ch.data   = '0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = '0;
      csr_ch.wdata  = '0;
      cur_quantum   = 16'd10;
      cur_min       = 3'd1;
      cur_max       = 3'd5;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed opening with the reset defaults: quantum 10, priorities 1..5.
      send_request(make_req(prq_pkg::MODE_MULTI, 3'd0, 16'd0, 32'd10, 8'd7));  // empty
      send_request(make_req(prq_pkg::MODE_REPEAT, 3'd0, 16'd0, 32'd10, 8'd3)); // empty
      send_request(make_req(prq_pkg::MODE_EXTRACT, 3'd3, 16'd0, 32'd0, 8'd0)); // none
      send_request(make_req(prq_pkg::MODE_INSERT, 3'd5, 16'd1, 32'd10, 8'd0));
      send_request(make_req(prq_pkg::MODE_INSERT, 3'd1, 16'd2, 32'd20, 8'd0));
      send_request(make_req(prq_pkg::MODE_INSERT, 3'd3, 16'd3, 32'd30, 8'd0));
      send_request(make_req(prq_pkg::MODE_INSERT, 3'd3, 16'hFFFF, 32'd40, 8'd0));
      send_request(make_req(prq_pkg::MODE_INSERT, 3'd3, 16'd3, 32'd50, 8'd0));  // merge
      // Zero time, priority below and above the range, time off the quantum.
      send_request(make_req(prq_pkg::MODE_INSERT, 3'd3, 16'd9, 32'd0, 8'd0));
      send_request(make_req(prq_pkg::MODE_INSERT, 3'd0, 16'd9, 32'd10, 8'd0));
      send_request(make_req(prq_pkg::MODE_INSERT, 3'd6, 16'd9, 32'd10, 8'd0));
      send_request(make_req(prq_pkg::MODE_INSERT, 3'd3, 16'd9, 32'd15, 8'd0));
      // Two large merges into one process saturate its time.
      send_request(make_req(prq_pkg::MODE_INSERT, 3'd1, 16'd2, 32'hFFFF_FFF0, 8'd0));
      send_request(make_req(prq_pkg::MODE_INSERT, 3'd1, 16'd2, 32'hFFFF_FFF0, 8'd0));
      // Bad slices on both kinds of run.
      send_request(make_req(prq_pkg::MODE_MULTI, 3'd0, 16'd0, 32'd0, 8'd255));
      send_request(make_req(prq_pkg::MODE_REPEAT, 3'd0, 16'd0, 32'd7, 8'd4));
      send_request(make_req(prq_pkg::MODE_MULTI, 3'd0, 16'd0, 32'd10, 8'd0));
      send_request(make_req(prq_pkg::MODE_MULTI, 3'd0, 16'd0, 32'd20, 8'd2));
      send_request(make_req(prq_pkg::MODE_REPEAT, 3'd0, 16'd0, 32'd30, 8'd3));
      send_request(make_req(prq_pkg::MODE_EXTRACT, 3'd3, 16'd0, 32'd0, 8'd0));
      send_request(make_req(prq_pkg::MODE_EXTRACT, 3'd7, 16'd0, 32'd0, 8'd0));
      send_request(make_req(3'd5, 3'd0, 16'd0, 32'd0, 8'd0));
      send_request(make_req(3'd7, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
      send_request(make_req(prq_pkg::MODE_MULTI, 3'd0, 16'd0, 32'hFFFF_FFF0, 8'd255));
      send_request(make_req(prq_pkg::MODE_CLEAR, 3'd0, 16'd0, 32'd0, 8'd0));

      // No idling, default registers.
      run_random(30);

      // Widest range and the smallest quantum, sender idling. The table is
      // filled with one priority past full, then emptied in one extraction.
      configure(16'd1, 3'd0, 3'd7);
      send_idle_pct = 52;
      send_request(make_req(prq_pkg::MODE_CLEAR, 3'd0, 16'd0, 32'd0, 8'd0));
      for (int k = 0; k < prq_pkg::TableEntries + 1; k++)
         send_request(make_req(prq_pkg::MODE_INSERT, 3'd2, 16'(100 + k),
                               32'($urandom_range(1, 99)), 8'd0));
      send_request(make_req(prq_pkg::MODE_EXTRACT, 3'd2, 16'd0, 32'd0, 8'd0));
      run_random(30);

      // Largest quantum, a single priority, receiver stalling. The receiver
      // then holds off for a long stretch while requests keep coming, so the
      // queue backs up and stops taking requests.
      configure(16'hFFFF, 3'd7, 3'd7);
      send_idle_pct = 0;
      recv_stall_pct = 52;
      hold_cycles = 600;
      run_random(30);
      // The sender pauses here until every response is in.
      wait_drained();

      // An empty range rejects every insert; then a middle setting with both
      // sides idling.
      configure(16'd3, 3'd6, 3'd1);
      run_random(8);
      configure(16'd3, 3'd2, 3'd6);
      send_idle_pct = 29;
      recv_stall_pct = 29;
      run_random(45);

      wait_drained();
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### files.f
design/prq_pkg.sv
design/prq_if.sv
design/prq_csr_if.sv
design/prq_datapath.sv
design/prq_ctrl.sv
design/priority_run_queue.sv
design/prq_checker.sv
tb/priority_run_queue_checker.sv
tb/priority_run_queue_tb.sv
